[design/lavl_pkg.sv]
// Package with the shared types, widths and constants of the lux average and level block.
package lavl_pkg;

    // Ring depth and the widths that follow from it.
    localparam int SAMPLE_COUNT = 8;
    localparam int SLOT_W       = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
    localparam int FILL_W       = $clog2(SAMPLE_COUNT + 1);
    localparam int LUX_W        = 20;
    localparam int SUM_W        = LUX_W + $clog2(SAMPLE_COUNT);
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);

    // Fixed field widths.
    localparam int RAW_W       = 16;
    localparam int LEVEL_W     = 3;
    localparam int LIMIT_W     = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 24;
    localparam int M_TUSER_W   = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Count scaling: raw * 40 (or * 20) then a divide by three through a reciprocal.
    localparam int SCALED_W                = 22;
    localparam int RECIP_W                 = 24;
    localparam int RECIP_SHIFT             = 25;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd11184811;

    // A raw count of all ones marks a failed sensor read.
    localparam logic [RAW_W-1:0] FAIL_CODE = 16'hFFFF;

    // Light level codes.
    localparam logic [LEVEL_W-1:0] LEVEL_NO_DATA     = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_DARK        = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_DIM         = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT      = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_VERY_BRIGHT = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_RES     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DARK_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_LIMIT    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHT_LIMIT = 2'd3;

    // Configuration reset values.
    localparam logic [LIMIT_W-1:0] DARK_LIMIT_RESET   = 16'd10;
    localparam logic [LIMIT_W-1:0] DIM_LIMIT_RESET    = 16'd200;
    localparam logic [LIMIT_W-1:0] BRIGHT_LIMIT_RESET = 16'd1000;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_RECIP,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

[design/lavl_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module lavl_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8
) (
    input  logic                                     aclk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/lavl_divider.sv]
// Restoring bit-serial divider of the running sum by the fill count.
module lavl_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [lavl_pkg::SUM_W-1:0]     dividend,
    input  logic [lavl_pkg::FILL_W-1:0]    divisor,
    output lavl_pkg::div_status_t          status,
    output logic [lavl_pkg::SUM_W-1:0]     quotient
);

    logic [lavl_pkg::SUM_W-1:0]     quo_reg, quo_next;
    logic [lavl_pkg::FILL_W-1:0]    rem_reg, rem_next;
    logic [lavl_pkg::FILL_W-1:0]    divisor_reg;
    logic [lavl_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic [lavl_pkg::FILL_W:0]      shifted;
    logic [lavl_pkg::FILL_W+1:0]    diff;
    logic                           fits;

    // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted  = {rem_reg, quo_reg[lavl_pkg::SUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, divisor_reg};
        fits     = ~diff[lavl_pkg::FILL_W+1];
        rem_next = fits ? diff[lavl_pkg::FILL_W-1:0] : shifted[lavl_pkg::FILL_W-1:0];
        quo_next = {quo_reg[lavl_pkg::SUM_W-2:0], fits};
    end

    // Control: a start loads the operands, then SUM_W steps follow.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= lavl_pkg::DIV_CNT_W'(lavl_pkg::SUM_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == lavl_pkg::DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = busy_reg && (cnt_reg == lavl_pkg::DIV_CNT_W'(1));
    assign quotient    = quo_reg;

endmodule

[design/lux_average_and_level_top.sv]
// Top level of the lux average and level block: sequencer, sample ring and classifier.
//
// Usage: each transaction on the s_ channel carries one raw light count in
// s_tdata. Every count yields exactly one result transaction on the m_
// channel: the averaged lux (1/16 lux units) in m_tdata, the light level and
// the reading-accepted flag in m_tuser. A count of all ones is a failed read;
// its result repeats the held average with level "no data".
// A good count passes through the scale, reciprocal, ring update and divide
// steps before its result is loaded; the bit-serial divider works out one
// quotient bit per cycle over the SUM_W-bit running sum. A failed read goes
// from acceptance straight to the result load. The block takes one count at
// a time and accepts the next count only once the previous result is loaded.
// Configuration writes through cfg_wr_en/cfg_index/cfg_wdata take effect at
// once and are meant for idle periods only.
// Reset clears the fill count, write slot, running sum, held average and the
// output channel, and s_tready stays low while reset is held; the sample RAM
// is not cleared, since only written entries are ever read back. When the
// receiver stalls, the result holds in the output register and the next
// result waits until it is taken.
module lux_average_and_level_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] raw_count
    input  logic [lavl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [19:0] average_lux, [23:20] zero
    output logic [lavl_pkg::M_TDATA_W-1:0]   m_tdata,
    // [2:0] light_level, [3] reading_ok
    output logic [lavl_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [lavl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lavl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    lavl_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic                          half_res_reg;
    logic [lavl_pkg::LIMIT_W-1:0]  dark_limit_reg;
    logic [lavl_pkg::LIMIT_W-1:0]  dim_limit_reg;
    logic [lavl_pkg::LIMIT_W-1:0]  bright_limit_reg;

    // Ring state.
    logic [lavl_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [lavl_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [lavl_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [lavl_pkg::LUX_W-1:0]    held_avg_reg;

    // Per-item datapath.
    logic [lavl_pkg::RAW_W-1:0]    raw_reg;
    logic                          fail_reg;
    logic [lavl_pkg::SCALED_W-1:0] scaled_reg, scaled_next;
    logic [lavl_pkg::SCALED_W+lavl_pkg::RECIP_W-1:0] product;
    logic [lavl_pkg::LUX_W-1:0]    lux_reg;
    logic [lavl_pkg::LUX_W-1:0]    old_lux;
    logic                          ring_full;

    // Output register.
    logic                          m_valid_reg;
    logic [lavl_pkg::LUX_W-1:0]    m_avg_reg;
    logic [lavl_pkg::LEVEL_W-1:0]  m_level_reg;
    logic                          m_ok_reg;

    // Sequencer controls.
    logic                          s_accept;
    logic                          ram_rd_en;
    logic                          ram_wr_en;
    logic                          div_start;
    logic                          out_load;
    logic                          out_free;

    lavl_pkg::div_status_t         div_status;
    logic [lavl_pkg::SUM_W-1:0]    div_quotient;
    logic [lavl_pkg::LUX_W-1:0]    new_avg;
    logic [lavl_pkg::LEVEL_W-1:0]  new_level;
    logic [lavl_pkg::LUX_W-1:0]    dark_scaled, dim_scaled, bright_scaled;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_res_reg     <= 1'b0;
            dark_limit_reg   <= lavl_pkg::DARK_LIMIT_RESET;
            dim_limit_reg    <= lavl_pkg::DIM_LIMIT_RESET;
            bright_limit_reg <= lavl_pkg::BRIGHT_LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lavl_pkg::REG_HALF_RES:     half_res_reg     <= cfg_wdata[0];
                lavl_pkg::REG_DARK_LIMIT:   dark_limit_reg   <= cfg_wdata;
                lavl_pkg::REG_DIM_LIMIT:    dim_limit_reg    <= cfg_wdata;
                lavl_pkg::REG_BRIGHT_LIMIT: bright_limit_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lavl_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tdata[lavl_pkg::RAW_W-1:0] == lavl_pkg::FAIL_CODE)
                                 ? lavl_pkg::ST_DONE : lavl_pkg::ST_SCALE;
                end
            end
            lavl_pkg::ST_SCALE:  state_next = lavl_pkg::ST_RECIP;
            lavl_pkg::ST_RECIP:  state_next = lavl_pkg::ST_UPDATE;
            lavl_pkg::ST_UPDATE: state_next = lavl_pkg::ST_DIVIDE;
            lavl_pkg::ST_DIVIDE: begin
                if (div_status.done) begin
                    state_next = lavl_pkg::ST_DONE;
                end
            end
            lavl_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lavl_pkg::ST_IDLE;
                end
            end
            default: state_next = lavl_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready  = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            lavl_pkg::ST_IDLE: begin
                s_tready  = aresetn;
                ram_rd_en = s_tvalid && aresetn;
            end
            lavl_pkg::ST_UPDATE: begin
                ram_wr_en = 1'b1;
                div_start = 1'b1;
            end
            lavl_pkg::ST_DONE: out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lavl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Scaling by 40 or 20 through shifts and adds.
    always_comb begin
        if (half_res_reg) begin
            scaled_next = lavl_pkg::SCALED_W'({raw_reg, 4'b0000})
                        + lavl_pkg::SCALED_W'({raw_reg, 2'b00});
        end else begin
            scaled_next = lavl_pkg::SCALED_W'({raw_reg, 5'b00000})
                        + lavl_pkg::SCALED_W'({raw_reg, 3'b000});
        end
    end

    // Divide by three as a reciprocal multiply; exact for all scaled counts.
    assign product = {{lavl_pkg::RECIP_W{1'b0}}, scaled_reg}
                   * {{lavl_pkg::SCALED_W{1'b0}}, lavl_pkg::RECIP_MULT};

    // Ring bookkeeping: drop the overwritten entry once the ring is full.
    assign ring_full = (fill_reg == lavl_pkg::FILL_W'(lavl_pkg::SAMPLE_COUNT));
    always_comb begin
        sum_next  = (sum_reg - (ring_full ? lavl_pkg::SUM_W'(old_lux) : '0))
                  + lavl_pkg::SUM_W'(lux_reg);
        fill_next = ring_full ? fill_reg : fill_reg + 1'b1;
        slot_next = (slot_reg == lavl_pkg::SLOT_W'(lavl_pkg::SAMPLE_COUNT - 1))
                    ? '0 : slot_reg + 1'b1;
    end

    // Per-item datapath registers.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            raw_reg  <= s_tdata[lavl_pkg::RAW_W-1:0];
            fail_reg <= (s_tdata[lavl_pkg::RAW_W-1:0] == lavl_pkg::FAIL_CODE);
        end
        if (state_reg == lavl_pkg::ST_SCALE) begin
            scaled_reg <= scaled_next;
        end
        if (state_reg == lavl_pkg::ST_RECIP) begin
            lux_reg <= product[lavl_pkg::RECIP_SHIFT +: lavl_pkg::LUX_W];
        end
    end

    // Ring state and held average.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            held_avg_reg  <= '0;
        end else begin
            if (state_reg == lavl_pkg::ST_UPDATE) begin
                slot_reg <= slot_next;
                fill_reg <= fill_next;
                sum_reg  <= sum_next;
            end
            if (out_load && !fail_reg) begin
                held_avg_reg <= new_avg;
            end
        end
    end

    // Average and light level for the finished transaction.
    assign new_avg       = fail_reg ? held_avg_reg : div_quotient[lavl_pkg::LUX_W-1:0];
    assign dark_scaled   = {dark_limit_reg, 4'b0000};
    assign dim_scaled    = {dim_limit_reg, 4'b0000};
    assign bright_scaled = {bright_limit_reg, 4'b0000};

    always_comb begin
        if (fail_reg) begin
            new_level = lavl_pkg::LEVEL_NO_DATA;
        end else if (new_avg < dark_scaled) begin
            new_level = lavl_pkg::LEVEL_DARK;
        end else if (new_avg < dim_scaled) begin
            new_level = lavl_pkg::LEVEL_DIM;
        end else if (new_avg < bright_scaled) begin
            new_level = lavl_pkg::LEVEL_BRIGHT;
        end else begin
            new_level = lavl_pkg::LEVEL_VERY_BRIGHT;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_reg   <= new_avg;
            m_level_reg <= new_level;
            m_ok_reg    <= !fail_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = lavl_pkg::M_TDATA_W'(m_avg_reg);
    assign m_tuser  = {m_ok_reg, m_level_reg};

    // Sample ring storage; the slot is read at acceptance and written in the update step.
    lavl_ram #(
        .WIDTH (lavl_pkg::LUX_W),
        .DEPTH (lavl_pkg::SAMPLE_COUNT)
    ) u_sample_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (lux_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (old_lux)
    );

    // Serial divider for the mean.
    lavl_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (fill_next),
        .status   (div_status),
        .quotient (div_quotient)
    );

endmodule

[design/lavl_checker.sv]
// Port-level checker for the lux average and level block, bound to the top level.
module lavl_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lavl_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lavl_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lavl_pkg::M_TUSER_W-1:0] m_tuser
);

    // The block works on one count at a time: it is busy right after a transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while the previous count is still in work");

    // A rejected reading always reports no data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[3]) |-> (m_tuser[2:0] == lavl_pkg::LEVEL_NO_DATA))
    else $error("rejected reading carries a light level");

    // An accepted reading reports one of the four real levels.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[3]) |->
            (m_tuser[2:0] == lavl_pkg::LEVEL_DARK || m_tuser[2:0] == lavl_pkg::LEVEL_DIM ||
             m_tuser[2:0] == lavl_pkg::LEVEL_BRIGHT ||
             m_tuser[2:0] == lavl_pkg::LEVEL_VERY_BRIGHT))
    else $error("accepted reading carries no valid light level");

    // A stalled result holds its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed or dropped");

    // Reset empties the output channel.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind lux_average_and_level_top lavl_checker u_lavl_checker (.*);
